### rtl/core/trem_pkg.sv
// ----------------------------------------------------------------------------
// Tremolo package
// Shared constants, word types, sequencer codes and the quarter-wave sine
// table used by the tremolo amplitude modulator.
// ----------------------------------------------------------------------------
package trem_pkg;

	// Quarter-wave table size and the widths that follow from it.
	localparam int SINE_ENTRIES = 256;
	localparam int IDX_W        = $clog2(4 * SINE_ENTRIES);
	localparam int ADDR_W       = $clog2(SINE_ENTRIES + 1);

	// Field and datapath widths.
	localparam int SAMPLE_W   = 24;
	localparam int PRESSURE_W = 16;
	localparam int PHASE_W    = 32;
	localparam int DEPTH_W    = 15;
	localparam int SINE_W     = 15;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 24;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int P_W        = PRESSURE_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_DEPTH      = 2'd1,
		REG_USE_AT     = 2'd2
	} reg_idx_t;

	// Words moved by the two channels.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       frame_end;
		logic [PRESSURE_W-1:0]      pressure;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       clipped;
	} out_word_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_TAB,
		S_M1,
		S_M2,
		S_GAIN,
		S_M3,
		S_SAT
	} state_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_IDX,
		MUL_DS,
		MUL_MP,
		MUL_GS
	} mul_op_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic    take;
		mul_op_t mul_op;
		logic    mul_en;
		logic    tab_en;
		logic    gain_en;
		logic    out_en;
	} ctrl_t;

	// Sine table: entry k = round(sin(pi/2 * k/N) * 32768), capped at 32767.
	typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_ENTRIES];

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	// Integer Taylor series in Q30, evaluated at elaboration.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int k = 0; k <= SINE_ENTRIES; k++) begin
			x    = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_ENTRIES);
			term = x;
			sum  = x;
			for (int n = 1; n <= 7; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				// Divide by (2n)(2n+1) for the n-th term.
				case (n)
					1:       term = term / 64'd6;
					2:       term = term / 64'd20;
					3:       term = term / 64'd42;
					4:       term = term / 64'd72;
					5:       term = term / 64'd110;
					6:       term = term / 64'd156;
					default: term = term / 64'd210;
				endcase
				if (n % 2 == 1) begin
					sum = (sum > term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum + 64'd16384) >> 15;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			tab[k] = v[SINE_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

### rtl/core/trem_mul.sv
// ----------------------------------------------------------------------------
// Tremolo shared multiplier
// One unsigned 32 x 24 multiplier with operand selection and a product
// register, reused for every product of one sample.
// ----------------------------------------------------------------------------
module trem_mul (
	input  logic                                clk,
	input  trem_pkg::mul_op_t                   op,
	input  logic                                en,
	input  logic [trem_pkg::PHASE_W-1:0]        phase,
	input  logic [trem_pkg::DEPTH_W-1:0]        depth,
	input  logic [trem_pkg::SINE_W-1:0]         smag,
	input  logic [trem_pkg::P_W-1:0]            p,
	input  logic [trem_pkg::MUL_A_W-1:0]        gmag,
	input  logic [trem_pkg::SAMPLE_W-1:0]       smp_mag,
	output logic [trem_pkg::PROD_W-1:0]         prod
);

	localparam logic [trem_pkg::MUL_B_W-1:0] FOUR_N =
		trem_pkg::MUL_B_W'(4 * trem_pkg::SINE_ENTRIES);

	logic [trem_pkg::MUL_A_W-1:0] a;
	logic [trem_pkg::MUL_B_W-1:0] b;
	logic [trem_pkg::PROD_W-1:0]  prod_q;

	// Select the operands for the current step.
	always_comb begin
		unique case (op)
			trem_pkg::MUL_IDX: begin
				a = phase;
				b = FOUR_N;
			end
			trem_pkg::MUL_DS: begin
				a = trem_pkg::MUL_A_W'(depth);
				b = trem_pkg::MUL_B_W'(smag);
			end
			trem_pkg::MUL_MP: begin
				a = trem_pkg::MUL_A_W'(prod_q[29:0]);
				b = trem_pkg::MUL_B_W'(p);
			end
			trem_pkg::MUL_GS: begin
				a = gmag;
				b = smp_mag;
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	// Registered product.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= trem_pkg::PROD_W'(a) * trem_pkg::PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

### rtl/core/trem_lfo.sv
// ----------------------------------------------------------------------------
// Tremolo LFO
// Holds the phase accumulator and turns the table index into a sine
// magnitude and sign through the quarter-wave table.
// ----------------------------------------------------------------------------
module trem_lfo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [trem_pkg::PHASE_W-1:0]      phase_step,
	input  logic                              adv,
	input  logic                              tab_en,
	input  logic [trem_pkg::IDX_W-1:0]        idx,
	output logic [trem_pkg::PHASE_W-1:0]      phase,
	output logic [trem_pkg::SINE_W-1:0]       smag,
	output logic                              sneg
);

	localparam logic [trem_pkg::IDX_W-1:0] N1 = trem_pkg::IDX_W'(trem_pkg::SINE_ENTRIES);
	localparam logic [trem_pkg::IDX_W-1:0] N2 = trem_pkg::IDX_W'(2 * trem_pkg::SINE_ENTRIES);
	localparam logic [trem_pkg::IDX_W-1:0] N3 = trem_pkg::IDX_W'(3 * trem_pkg::SINE_ENTRIES);
	localparam logic [trem_pkg::ADDR_W-1:0] NA = trem_pkg::ADDR_W'(trem_pkg::SINE_ENTRIES);

	logic [trem_pkg::PHASE_W-1:0] phase_q;
	logic [1:0]                   quad;
	logic [trem_pkg::IDX_W-1:0]   base;
	logic [trem_pkg::IDX_W-1:0]   kfull;
	logic [trem_pkg::ADDR_W-1:0]  k;
	logic [trem_pkg::ADDR_W-1:0]  addr;
	logic [trem_pkg::SINE_W-1:0]  smag_q;
	logic                         sneg_q;

	// Phase accumulator, advanced once per frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (adv) begin
			phase_q <= phase_q + phase_step;
		end
	end

	// Split the index into quadrant and offset within the quadrant.
	always_comb begin
		if (idx >= N3) begin
			quad = 2'd3;
			base = N3;
		end else if (idx >= N2) begin
			quad = 2'd2;
			base = N2;
		end else if (idx >= N1) begin
			quad = 2'd1;
			base = N1;
		end else begin
			quad = 2'd0;
			base = '0;
		end
		kfull = idx - base;
		k     = kfull[trem_pkg::ADDR_W-1:0];
		addr  = quad[0] ? (NA - k) : k;
	end

	// Registered table read.
	always_ff @(posedge clk) begin
		if (tab_en) begin
			smag_q <= trem_pkg::SINE_TAB[addr];
			sneg_q <= quad[1];
		end
	end

	assign phase = phase_q;
	assign smag  = smag_q;
	assign sneg  = sneg_q;

endmodule

### rtl/core/trem_ctrl.sv
// ----------------------------------------------------------------------------
// Tremolo sequencer
// Steps one sample through the shared multiplier and drives the
// input stall.
// ----------------------------------------------------------------------------
module trem_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	output logic            in_stall,
	output trem_pkg::ctrl_t ctrl
);

	trem_pkg::state_t state_q;
	trem_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trem_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control outputs.
	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		ctrl.mul_op  = trem_pkg::MUL_IDX;
		in_stall     = (state_q != trem_pkg::S_IDLE);
		unique case (state_q)
			trem_pkg::S_IDLE: begin
				if (in_valid) begin
					ctrl.take   = 1'b1;
					ctrl.mul_en = 1'b1;
					state_d     = trem_pkg::S_TAB;
				end
			end
			trem_pkg::S_TAB: begin
				ctrl.tab_en = 1'b1;
				state_d     = trem_pkg::S_M1;
			end
			trem_pkg::S_M1: begin
				ctrl.mul_op = trem_pkg::MUL_DS;
				ctrl.mul_en = 1'b1;
				state_d     = trem_pkg::S_M2;
			end
			trem_pkg::S_M2: begin
				ctrl.mul_op = trem_pkg::MUL_MP;
				ctrl.mul_en = 1'b1;
				state_d     = trem_pkg::S_GAIN;
			end
			trem_pkg::S_GAIN: begin
				ctrl.gain_en = 1'b1;
				state_d      = trem_pkg::S_M3;
			end
			trem_pkg::S_M3: begin
				ctrl.mul_op = trem_pkg::MUL_GS;
				ctrl.mul_en = 1'b1;
				state_d     = trem_pkg::S_SAT;
			end
			trem_pkg::S_SAT: begin
				if (out_free) begin
					ctrl.out_en = 1'b1;
					state_d     = trem_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = trem_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/tremolo_amplitude_modulator_top.sv
// ----------------------------------------------------------------------------
// Tremolo amplitude modulator
// Multiplies each sample by 1 + pressure * depth * sin(phase) with a sine
// LFO that advances once per frame; the result saturates to 24 bits.
//
//   Channel   Signals                          Word
//   input     in_valid, in_stall, in_word      sample_in, frame_end, pressure
//   output    out_valid, out_stall, out_word   sample_out, clipped
//   config    cfg_we, cfg_index, cfg_data      phase_step, depth, aftertouch_on
//
// Each sample is stepped through the four products that share a single
// multiplier, so a new sample is not accepted until the last one is done.
// The input is stalled while a sample is in flight and accepted again the
// cycle after it is done.
// A finished result waits in the output register; the last step holds while
// the output is stalled and still full. Reset clears the phase, the
// configuration registers, the output valid flag and the control state.
// ----------------------------------------------------------------------------
module tremolo_amplitude_modulator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  trem_pkg::in_word_t                  in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output trem_pkg::out_word_t                 out_word,
	input  logic                                cfg_we,
	input  logic [trem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [trem_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [trem_pkg::P_W-1:0] P_ONE = trem_pkg::P_W'(65536);
	localparam logic [26:0] Q_POS_MAX = 27'd8388607;
	localparam logic [26:0] Q_NEG_MAX = 27'd8388608;

	// Configuration registers.
	logic [trem_pkg::PHASE_W-1:0] phase_step_q;
	logic [trem_pkg::DEPTH_W-1:0] depth_q;
	logic                         use_at_q;

	// Per-sample registers.
	logic signed [trem_pkg::SAMPLE_W-1:0] sample_q;
	logic                                 frame_end_q;
	logic [trem_pkg::P_W-1:0]             p_q;
	logic [trem_pkg::MUL_A_W-1:0]         gmag_q;
	logic                                 gneg_q;

	// Output register.
	logic                out_valid_q;
	trem_pkg::out_word_t out_word_q;

	trem_pkg::ctrl_t               ctrl;
	logic                          out_free;
	logic [trem_pkg::PROD_W-1:0]   prod;
	logic [trem_pkg::PHASE_W-1:0]  phase;
	logic [trem_pkg::SINE_W-1:0]   smag;
	logic                          sneg;
	logic [trem_pkg::SAMPLE_W-1:0] smp_mag;

	// Gain and result arithmetic.
	logic [47:0]        m_rnd;
	logic [32:0]        m30;
	logic signed [33:0] gain;
	logic [33:0]        gain_abs;
	logic [56:0]        q_rnd;
	logic [26:0]        q;
	logic               yneg;
	trem_pkg::out_word_t res;

	assign out_free = !out_valid_q || !out_stall;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			depth_q      <= '0;
			use_at_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trem_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
				trem_pkg::REG_DEPTH:      depth_q      <= cfg_data[trem_pkg::DEPTH_W-1:0];
				trem_pkg::REG_USE_AT:     use_at_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Capture the input word and the pressure factor.
	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			sample_q    <= in_word.sample_in;
			frame_end_q <= in_word.frame_end;
			p_q         <= use_at_q ? trem_pkg::P_W'(in_word.pressure) : P_ONE;
		end
	end

	trem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_stall (in_stall),
		.ctrl     (ctrl)
	);

	trem_lfo u_lfo (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_step (phase_step_q),
		.adv        (ctrl.out_en && frame_end_q),
		.tab_en     (ctrl.tab_en),
		.idx        (prod[trem_pkg::PHASE_W +: trem_pkg::IDX_W]),
		.phase      (phase),
		.smag       (smag),
		.sneg       (sneg)
	);

	// Magnitude of the sample for the final product.
	assign smp_mag = sample_q[trem_pkg::SAMPLE_W-1] ? (-sample_q) : sample_q;

	trem_mul u_mul (
		.clk     (clk),
		.op      (ctrl.mul_op),
		.en      (ctrl.mul_en),
		.phase   (phase),
		.depth   (depth_q),
		.smag    (smag),
		.p       (p_q),
		.gmag    (gmag_q),
		.smp_mag (smp_mag),
		.prod    (prod)
	);

	// Round the modulation term and form the signed gain in Q2.30.
	always_comb begin
		m_rnd    = prod[47:0] + 48'd16384;
		m30      = m_rnd[47:15];
		gain     = sneg ? (34'sd1073741824 - $signed({1'b0, m30}))
		                : (34'sd1073741824 + $signed({1'b0, m30}));
		gain_abs = gain[33] ? 34'(-gain) : 34'(gain);
	end

	always_ff @(posedge clk) begin
		if (ctrl.gain_en) begin
			gmag_q <= gain_abs[trem_pkg::MUL_A_W-1:0];
			gneg_q <= gain[33];
		end
	end

	// Round half away from zero, then saturate to 24 bits.
	always_comb begin
		q_rnd = 57'(prod) + 57'd536870912;
		q     = q_rnd[56:30];
		yneg  = (sample_q[trem_pkg::SAMPLE_W-1] != gneg_q) && (q != '0);
		res   = '0;
		if (yneg) begin
			if (q > Q_NEG_MAX) begin
				res.sample_out = -24'sd8388608;
				res.clipped    = 1'b1;
			end else begin
				res.sample_out = -$signed(q[trem_pkg::SAMPLE_W-1:0]);
			end
		end else begin
			if (q > Q_POS_MAX) begin
				res.sample_out = 24'sd8388607;
				res.clipped    = 1'b1;
			end else begin
				res.sample_out = $signed(q[trem_pkg::SAMPLE_W-1:0]);
			end
		end
	end

	// Output register: holds a finished word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_en) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
